FILE: hw/rtl/mpd_pkg.sv
// Shared types, widths and codes for the mesh packet deframer.
`timescale 1ns / 1ps

package mpd_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned TAG_W      = 5;
  localparam int unsigned OFFSET_W   = 24;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned CFG_IDX_W  = 8;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned LEN_W      = 32;
  localparam int unsigned FRAMES_W   = 17;

  // Field currently being parsed; doubles as the field tag of a result.
  typedef enum logic [TAG_W-1:0] {
    PH_VERSION  = 5'd0,
    PH_TYPE     = 5'd1,
    PH_ID       = 5'd2,
    PH_PRIORITY = 5'd3,
    PH_TTL      = 5'd4,
    PH_TSTAMP   = 5'd5,
    PH_SRCLEN   = 5'd6,
    PH_SRC      = 5'd7,
    PH_DSTLEN   = 5'd8,
    PH_DST      = 5'd9,
    PH_NONCELEN = 5'd10,
    PH_NONCE    = 5'd11,
    PH_PAYLEN   = 5'd12,
    PH_PAYLOAD  = 5'd13,
    PH_SIGLEN   = 5'd14,
    PH_SIG      = 5'd15,
    PH_IGNORED  = 5'd16
  } phase_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_TOO_SHORT = 3'd1,
    ST_TRUNCATED = 3'd2,
    ST_ID_LONG   = 3'd3,
    ST_NONCE     = 3'd4,
    ST_PAYLOAD   = 3'd5
  } status_e;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ID    = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NONCE_LEN = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME = 8'd3;

  localparam logic [15:0] RST_MAX_ID    = 16'd255;
  localparam logic [15:0] RST_NONCE_LEN = 16'd8;
  localparam logic [23:0] RST_MAX_PAY   = 24'd65536;
  localparam logic [15:0] RST_MIN_FRAME = 16'd51;

  typedef struct packed {
    logic [15:0] max_id_length;
    logic [15:0] nonce_length;
    logic [23:0] max_payload_length;
    logic [15:0] min_frame_length;
  } cfg_t;

  typedef struct packed {
    phase_e                field_tag;
    logic [BYTE_W-1:0]     field_data;
    logic [OFFSET_W-1:0]   offset_in_field;
    logic                  data_valid;
    logic                  frame_end;
    status_e               frame_status;
  } result_t;

endpackage

FILE: hw/rtl/mpd_if.sv
// Stream and configuration channel interfaces of the mesh packet deframer.
`timescale 1ns / 1ps

interface mpd_in_if;
  import mpd_pkg::*;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              is_final;

  modport source (output valid, output rx_byte, output is_final, input ready);
  modport sink   (input valid, input rx_byte, input is_final, output ready);
endinterface

interface mpd_out_if;
  import mpd_pkg::*;
  logic                valid;
  logic                ready;
  logic [TAG_W-1:0]    field_tag;
  logic [BYTE_W-1:0]   field_data;
  logic [OFFSET_W-1:0] offset_in_field;
  logic                data_valid;
  logic                frame_end;
  logic [STATUS_W-1:0] frame_status;

  modport source (output valid, output field_tag, output field_data, output offset_in_field,
                  output data_valid, output frame_end, output frame_status, input ready);
  modport sink   (input valid, input field_tag, input field_data, input offset_in_field,
                  input data_valid, input frame_end, input frame_status, output ready);
endinterface

interface mpd_cfg_if;
  import mpd_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] reg_data;

  modport source (output valid, output reg_index, output reg_data, input ready);
  modport sink   (input valid, input reg_index, input reg_data, output ready);
endinterface

FILE: hw/rtl/mpd_cfg_regs.sv
// Configuration register file of the mesh packet deframer.
`timescale 1ns / 1ps

module mpd_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [mpd_pkg::CFG_IDX_W-1:0]  wr_index_i,
  input  logic [mpd_pkg::CFG_DATA_W-1:0] wr_data_i,
  output mpd_pkg::cfg_t                  cfg_o
);
  import mpd_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_id_length      <= RST_MAX_ID;
      cfg_q.nonce_length       <= RST_NONCE_LEN;
      cfg_q.max_payload_length <= RST_MAX_PAY;
      cfg_q.min_frame_length   <= RST_MIN_FRAME;
    end else if (wr_en_i) begin
      unique case (wr_index_i)
        CFG_MAX_ID:    cfg_q.max_id_length      <= wr_data_i[15:0];
        CFG_NONCE_LEN: cfg_q.nonce_length       <= wr_data_i[15:0];
        CFG_MAX_PAY:   cfg_q.max_payload_length <= wr_data_i[23:0];
        CFG_MIN_FRAME: cfg_q.min_frame_length   <= wr_data_i[15:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hw/rtl/mpd_parser.sv
// Per-byte parse step: phase tracking, length checks and frame status.
`timescale 1ns / 1ps

module mpd_parser #(
  parameter int unsigned ID_BYTES   = 16,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [mpd_pkg::BYTE_W-1:0] rx_byte_i,
  input  logic                       is_final_i,
  input  mpd_pkg::cfg_t              cfg_i,
  output mpd_pkg::result_t           result_o
);
  import mpd_pkg::*;

  localparam logic [LEN_W-1:0] COUNT_MAX = LEN_W'((33'd1 << COUNT_BITS) - 33'd1);

  phase_e                phase_q, phase_d;
  logic [COUNT_BITS-1:0] count_q, count_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [FRAMES_W-1:0]   frames_q, frames_d;
  status_e               err_q, err_d;

  logic                  active, is_len, last, raised;
  logic [COUNT_BITS:0]   off_inc;
  logic [LEN_W-1:0]      size, byte_ext, off_ext;
  logic [TAG_W-1:0]      phase_raw;
  status_e               len_err, status;

  always_comb begin
    active    = (phase_q != PH_IGNORED);
    phase_raw = phase_q;
    byte_ext  = LEN_W'(rx_byte_i);
    off_ext   = LEN_W'(count_q);
    off_inc   = {1'b0, count_q} + {{COUNT_BITS{1'b0}}, 1'b1};

    is_len  = 1'b0;
    size    = '0;
    case (phase_q)
      PH_VERSION, PH_TYPE, PH_PRIORITY: size = LEN_W'(1);
      PH_ID:      size = LEN_W'(ID_BYTES);
      PH_TTL:     size = LEN_W'(4);
      PH_TSTAMP:  size = LEN_W'(8);
      PH_SRCLEN, PH_DSTLEN, PH_NONCELEN, PH_SIGLEN: begin
        size   = LEN_W'(2);
        is_len = 1'b1;
      end
      PH_PAYLEN: begin
        size   = LEN_W'(4);
        is_len = 1'b1;
      end
      PH_SRC, PH_DST, PH_NONCE, PH_PAYLOAD, PH_SIG: begin
        size = len_q;
      end
      default: size = '0;
    endcase

    // Assemble the length prefix LSB first.
    len_d = len_q;
    if (is_len && (count_q[COUNT_BITS-1:2] == '0)) begin
      case (count_q[1:0])
        2'd0:    len_d = byte_ext;
        2'd1:    len_d = len_q | (byte_ext << 8);
        2'd2:    len_d = len_q | (byte_ext << 16);
        default: len_d = len_q | (byte_ext << 24);
      endcase
    end

    last = active && (LEN_W'(off_inc) >= size);

    len_err = ST_OK;
    case (phase_q)
      PH_SRCLEN, PH_DSTLEN:
        if (len_d > LEN_W'(cfg_i.max_id_length)) len_err = ST_ID_LONG;
      PH_NONCELEN:
        if (len_d != LEN_W'(cfg_i.nonce_length)) len_err = ST_NONCE;
      PH_PAYLEN:
        if (len_d[LEN_W-1] || (len_d > LEN_W'(cfg_i.max_payload_length)) ||
            (len_d > COUNT_MAX)) len_err = ST_PAYLOAD;
      default: len_err = ST_OK;
    endcase

    raised  = last && is_len && (len_err != ST_OK);
    err_d   = raised ? len_err : err_q;
    phase_d = phase_q;
    count_d = count_q;
    if (last) begin
      count_d = '0;
      if (raised)                       phase_d = PH_IGNORED;
      else if (is_len && len_d == '0)   phase_d = phase_e'(phase_raw + 5'd2);
      else                              phase_d = phase_e'(phase_raw + 5'd1);
    end else if (active) begin
      count_d = off_inc[COUNT_BITS-1:0];
    end

    // Frame byte count saturates above any legal minimum.
    frames_d = frames_q[FRAMES_W-1] ? frames_q : frames_q + FRAMES_W'(1);

    status = ST_OK;
    if (is_final_i) begin
      if (frames_d < FRAMES_W'(cfg_i.min_frame_length)) status = ST_TOO_SHORT;
      else if (err_d != ST_OK)                          status = err_d;
      else if (phase_d != PH_IGNORED)                   status = ST_TRUNCATED;
    end

    result_o.field_tag       = phase_q;
    result_o.field_data      = rx_byte_i;
    result_o.offset_in_field = active ? off_ext[OFFSET_W-1:0] : '0;
    result_o.data_valid      = active && !raised;
    result_o.frame_end       = is_final_i;
    result_o.frame_status    = status;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_VERSION;
      count_q  <= '0;
      len_q    <= '0;
      frames_q <= '0;
      err_q    <= ST_OK;
    end else if (step_i) begin
      if (is_final_i) begin
        phase_q  <= PH_VERSION;
        count_q  <= '0;
        len_q    <= '0;
        frames_q <= '0;
        err_q    <= ST_OK;
      end else begin
        phase_q  <= phase_d;
        count_q  <= count_d;
        len_q    <= len_d;
        frames_q <= frames_d;
        err_q    <= err_d;
      end
    end
  end

endmodule

FILE: hw/rtl/mesh_packet_deframer.sv
// Top level of the mesh packet deframer: input register, parse step, result register.
`timescale 1ns / 1ps

//  channel | modport | payload                                          | transfer
//  in_i    | sink    | rx_byte, is_final                                | valid & ready
//  out_o   | source  | field_tag, field_data, offset_in_field,          | valid & ready
//          |         | data_valid, frame_end, frame_status              |
//  cfg_i   | sink    | reg_index, reg_data (always ready)               | valid & ready
//
//  One byte per cycle sustained while out_o does not stall; a byte passes the input
//  register and then the result register before its result is presented on out_o. The
//  rate rests on the parse-phase update, a combinational step between the input register
//  and the result register.
//  Reset clears the parse state and loads the register defaults; no clearing pass.
//  A stall on out_o holds the result register and then the input register; the
//  input still takes a byte while a finished result waits, as long as a slot frees.

module mesh_packet_deframer #(
  parameter int unsigned ID_BYTES   = 16,
  parameter int unsigned COUNT_BITS = 24
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  mpd_in_if.sink   in_i,
  mpd_out_if.source out_o,
  mpd_cfg_if.sink  cfg_i
);
  import mpd_pkg::*;

  // Input register.
  logic              in_v_q;
  logic [BYTE_W-1:0] in_byte_q;
  logic              in_fin_q;
  // Result register.
  logic              out_v_q;
  result_t           res_q;

  result_t res;
  cfg_t    cfg;
  logic    advance;

  // Advance the held byte through the parser when the result slot frees.
  assign advance    = in_v_q && (!out_v_q || out_o.ready);
  assign in_i.ready = !in_v_q || advance;
  assign cfg_i.ready = 1'b1;

  mpd_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_i.valid),
    .wr_index_i (cfg_i.reg_index),
    .wr_data_i  (cfg_i.reg_data),
    .cfg_o      (cfg)
  );

  mpd_parser #(
    .ID_BYTES   (ID_BYTES),
    .COUNT_BITS (COUNT_BITS)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (advance),
    .rx_byte_i  (in_byte_q),
    .is_final_i (in_fin_q),
    .cfg_i      (cfg),
    .result_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  // Payload needs no reset; load it on each input transfer.
  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_byte_q <= in_i.rx_byte;
      in_fin_q  <= in_i.is_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= 1'b1;
    end else if (out_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_v_q;
  assign out_o.field_tag       = res_q.field_tag;
  assign out_o.field_data      = res_q.field_data;
  assign out_o.offset_in_field = res_q.offset_in_field;
  assign out_o.data_valid      = res_q.data_valid;
  assign out_o.frame_end       = res_q.frame_end;
  assign out_o.frame_status    = res_q.frame_status;

endmodule

FILE: hw/rtl/mpd_checker.sv
// Port-level assertions for the mesh packet deframer, bound to the top level.
`timescale 1ns / 1ps

module mpd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [mpd_pkg::TAG_W-1:0]    field_tag_i,
  input logic [mpd_pkg::BYTE_W-1:0]   field_data_i,
  input logic [mpd_pkg::OFFSET_W-1:0] offset_i,
  input logic                         data_valid_i,
  input logic                         frame_end_i,
  input logic [mpd_pkg::STATUS_W-1:0] frame_status_i
);
  import mpd_pkg::*;

  // Track whether the next result transfer opens a frame.
  logic frame_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_start_q <= 1'b1;
    end else if (out_valid_i && out_ready_i) begin
      frame_start_q <= frame_end_i;
    end
  end

  a_status_on_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !frame_end_i |-> frame_status_i == ST_OK)
    else $error("frame status set on a byte that does not end the frame");

  a_ignored_not_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && field_tag_i == PH_IGNORED |-> !data_valid_i && offset_i == '0)
    else $error("ignored byte flagged valid or with an offset");

  a_frame_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && frame_start_q |-> field_tag_i == PH_VERSION && offset_i == '0)
    else $error("frame does not open with the version byte");

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(field_data_i) &&
    $stable(field_tag_i))
    else $error("stalled result changed");

endmodule

bind mesh_packet_deframer mpd_checker u_mpd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .field_tag_i    (out_o.field_tag),
  .field_data_i   (out_o.field_data),
  .offset_i       (out_o.offset_in_field),
  .data_valid_i   (out_o.data_valid),
  .frame_end_i    (out_o.frame_end),
  .frame_status_i (out_o.frame_status)
);

FILE: tb/mesh_packet_deframer_test.sv
// Self-checking testbench for the mesh packet deframer: frames, errors, register settings.
`timescale 1ns / 1ps

module mesh_packet_deframer_test;
  import mpd_pkg::*;

  localparam int unsigned ID_BYTES   = 16;
  localparam int unsigned COUNT_BITS = 24;
  localparam logic [31:0] COUNT_MAX  = (32'd1 << COUNT_BITS) - 32'd1;
  // Cap on data bytes emitted for one field; a longer field just ends the frame truncated.
  localparam int unsigned DATA_CAP   = 32;
  // Input to output passes the input and result registers; allow a little slack before touching registers.
  localparam int unsigned SETTLE     = 4;

  logic clk_i;
  logic rst_ni;

  mpd_in_if  in_if ();
  mpd_out_if out_if ();
  mpd_cfg_if cfg_if ();

  mesh_packet_deframer #(
    .ID_BYTES  (ID_BYTES),
    .COUNT_BITS(COUNT_BITS)
  ) DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if),
    .cfg_i (cfg_if)
  );

  // Register shadow and parser state of the predictor.
  cfg_t        regs;
  logic [4:0]  cur_phase;
  logic [23:0] field_pos;
  logic [31:0] len_prefix;
  logic [31:0] frame_bytes;
  status_e     first_err;

  // Tagged bytes still owed by the block, oldest first.
  result_t     tagged_bytes_q[$];
  result_t     want;
  int unsigned mismatches;
  int unsigned bytes_sent;
  int unsigned stall_left;
  bit          no_idle;

  always #5 clk_i = ~clk_i;

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // Work out the tag, offset and status the block must produce for one byte, and
  // advance the parser state exactly as the block does.
  function automatic result_t parse_byte(input logic [7:0] b, input logic fin);
    result_t     r;
    logic [4:0]  ph;
    logic [31:0] off;
    logic [31:0] size;
    logic [4:0]  nxt;
    logic        is_len;
    logic        raised;
    status_e     e;
    status_e     st;
    ph     = cur_phase;
    off    = {8'd0, field_pos};
    raised = 1'b0;
    st     = ST_OK;
    if (ph < PH_IGNORED) begin
      case (ph)
        PH_VERSION, PH_TYPE, PH_PRIORITY:                  size = 32'd1;
        PH_ID:                                             size = ID_BYTES;
        PH_TTL, PH_PAYLEN:                                 size = 32'd4;
        PH_TSTAMP:                                         size = 32'd8;
        PH_SRCLEN, PH_DSTLEN, PH_NONCELEN, PH_SIGLEN:      size = 32'd2;
        default:                                           size = len_prefix;
      endcase
      // Length prefixes sit on the even phases from source length on.
      is_len = (ph >= PH_SRCLEN) && !ph[0];
      if (is_len) begin
        if (off == 0) len_prefix = {24'd0, b};
        else if (off < 4) len_prefix = len_prefix | ({24'd0, b} << (8 * off));
      end
      if (off + 1 >= size) begin
        nxt       = ph + 5'd1;
        field_pos = '0;
        if (is_len) begin
          e = ST_OK;
          if (ph == PH_SRCLEN || ph == PH_DSTLEN) begin
            if (len_prefix > {16'd0, regs.max_id_length}) e = ST_ID_LONG;
          end else if (ph == PH_NONCELEN) begin
            if (len_prefix != {16'd0, regs.nonce_length}) e = ST_NONCE;
          end else if (ph == PH_PAYLEN) begin
            if (len_prefix[31] || len_prefix > {8'd0, regs.max_payload_length} ||
                len_prefix > COUNT_MAX) e = ST_PAYLOAD;
          end
          if (e != ST_OK) begin
            first_err = e;
            raised    = 1'b1;
            nxt       = PH_IGNORED;
          end else if (len_prefix == 0) begin
            // skip an empty data field; an empty signature ends the frame
            nxt = ph + 5'd2;
          end
        end
        cur_phase = nxt;
      end else begin
        field_pos = off[23:0] + 24'd1;
      end
    end
    if (frame_bytes != 32'hFFFF_FFFF) frame_bytes++;
    if (fin) begin
      if (frame_bytes < {16'd0, regs.min_frame_length}) st = ST_TOO_SHORT;
      else if (first_err != ST_OK) st = first_err;
      else if (cur_phase != PH_IGNORED) st = ST_TRUNCATED;
    end
    r.field_tag       = phase_e'(ph);
    r.field_data      = b;
    r.offset_in_field = (ph < PH_IGNORED) ? off[23:0] : '0;
    r.data_valid      = (ph < PH_IGNORED) && !raised;
    r.frame_end       = fin;
    r.frame_status    = st;
    if (fin) begin
      cur_phase   = PH_VERSION;
      field_pos   = '0;
      len_prefix  = '0;
      frame_bytes = '0;
      first_err   = ST_OK;
    end
    return r;
  endfunction

  // Output side: random stalls, mostly short, a few long; none while no_idle is set.
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      out_if.ready <= 1'b0;
      stall_left = stall_left - 1;
    end else if (!no_idle && $urandom_range(0, 99) < 15) begin
      out_if.ready <= 1'b0;
      stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 39) : $urandom_range(0, 2);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // Compare every result transfer against the oldest tagged byte owed.
  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (tagged_bytes_q.size() == 0) begin
        $error("result with nothing pending: tag %0d data %0h",
               out_if.field_tag, out_if.field_data);
        mismatches++;
      end else begin
        want = tagged_bytes_q.pop_front();
        if (out_if.field_tag !== want.field_tag) begin
          $error("field_tag: expected %0d, got %0d", want.field_tag, out_if.field_tag);
          mismatches++;
        end
        if (out_if.field_data !== want.field_data) begin
          $error("field_data: expected %0h, got %0h", want.field_data, out_if.field_data);
          mismatches++;
        end
        if (out_if.offset_in_field !== want.offset_in_field) begin
          $error("offset_in_field: expected %0d, got %0d",
                 want.offset_in_field, out_if.offset_in_field);
          mismatches++;
        end
        if (out_if.data_valid !== want.data_valid) begin
          $error("data_valid: expected %0b, got %0b", want.data_valid, out_if.data_valid);
          mismatches++;
        end
        if (out_if.frame_end !== want.frame_end) begin
          $error("frame_end: expected %0b, got %0b", want.frame_end, out_if.frame_end);
          mismatches++;
        end
        if (out_if.frame_status !== want.frame_status) begin
          $error("frame_status: expected %0d, got %0d", want.frame_status, out_if.frame_status);
          mismatches++;
        end
      end
    end
  end

  // Transfer one byte, after a random gap, and record what it must produce.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int unsigned gap;
    gap = 0;
    if (!no_idle) begin
      if ($urandom_range(0, 99) >= 70)
        gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.rx_byte  <= b;
    in_if.is_final <= fin;
    do @(posedge clk_i); while (!in_if.ready);
    tagged_bytes_q.push_back(parse_byte(b, fin));
    bytes_sent++;
  endtask

  // Hold the input until every pending result has drained, then let the pipe settle.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (tagged_bytes_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // Write all four registers plus one unmapped index, with junk above each 16-bit field.
  task automatic set_config(input logic [23:0] max_id, input logic [23:0] nonce_bytes,
                            input logic [23:0] max_pay, input logic [23:0] min_frame);
    logic [CFG_IDX_W-1:0]  idx[5];
    logic [CFG_DATA_W-1:0] dat[5];
    wait_idle();
    idx[0] = CFG_MAX_ID;    dat[0] = {8'($urandom), max_id[15:0]};
    idx[1] = CFG_NONCE_LEN; dat[1] = {8'($urandom), nonce_bytes[15:0]};
    idx[2] = CFG_MAX_PAY;   dat[2] = max_pay;
    idx[3] = CFG_MIN_FRAME; dat[3] = {8'($urandom), min_frame[15:0]};
    idx[4] = 8'($urandom_range(CFG_MIN_FRAME + 1, 255));
    dat[4] = 24'($urandom);
    cfg_if.valid <= 1'b1;
    for (int i = 0; i < 5; i++) begin
      cfg_if.reg_index <= idx[i];
      cfg_if.reg_data  <= dat[i];
      do @(posedge clk_i); while (!cfg_if.ready);
      case (idx[i])
        CFG_MAX_ID:    regs.max_id_length      = dat[i][15:0];
        CFG_NONCE_LEN: regs.nonce_length       = dat[i][15:0];
        CFG_MAX_PAY:   regs.max_payload_length = dat[i][23:0];
        CFG_MIN_FRAME: regs.min_frame_length   = dat[i][15:0];
        default: ;
      endcase
    end
    cfg_if.valid <= 1'b0;
  endtask

  // Build one frame with the given prefixes and random content; optionally append
  // trailing bytes or cut it short at a random point. The last byte sent is final.
  task automatic send_frame(input logic [15:0] src_len, input logic [15:0] dst_len,
                            input logic [15:0] nonce_bytes, input logic [31:0] pay_len,
                            input logic [15:0] sig_len, input int unsigned trailing,
                            input bit cut);
    logic [7:0]  frame_q[$];
    logic [31:0] lens[5];
    int unsigned keep;
    lens = '{{16'd0, src_len}, {16'd0, dst_len}, {16'd0, nonce_bytes}, pay_len,
             {16'd0, sig_len}};
    // version, type, id, priority, ttl, timestamp
    repeat (3 + ID_BYTES + 12) frame_q.push_back(8'($urandom));
    for (int f = 0; f < 5; f++) begin
      for (int k = 0; k < ((f == 3) ? 4 : 2); k++) frame_q.push_back(lens[f][8*k +: 8]);
      repeat ((lens[f] > DATA_CAP) ? DATA_CAP : lens[f]) frame_q.push_back(8'($urandom));
    end
    repeat (trailing) frame_q.push_back(8'($urandom));
    keep = frame_q.size();
    if (cut && keep > 1) keep = $urandom_range(1, keep - 1);
    for (int i = 0; i < keep; i++) send_byte(frame_q[i], i == keep - 1);
  endtask

  // Frames at the reset settings: the smallest legal frame, a full frame, and a
  // destination id length right at the limit (its data is capped, so that frame
  // ends truncated).
  task automatic test_default_frames();
    send_frame(0, 0, 8, 0, 0, 0, 0);
    send_frame(3, 255, 8, 5, 4, 0, 0);
    send_frame(1, 2, 8, 17, 6, 0, 0);
  endtask

  // Frames cut short: too short under the default minimum, truncated without one.
  task automatic test_short_frames();
    send_byte(8'hFF, 1'b1);
    send_frame(2, 2, 8, 3, 2, 0, 1);
    set_config(255, 8, 65536, 0);
    send_byte(8'h00, 1'b1);
    send_frame(2, 2, 8, 3, 2, 0, 1);
    send_frame(4, 4, 8, 40, 8, 0, 1);
  endtask

  // Each length check, the payload bounds, and too short winning over an error.
  task automatic test_length_errors();
    set_config(255, 8, 65536, 0);
    send_frame(256, 0, 8, 0, 0, 0, 0);
    send_frame(0, 300, 8, 0, 0, 0, 0);
    send_frame(1, 1, 9, 0, 0, 0, 0);
    send_frame(0, 0, 8, 32'h8000_0000, 0, 0, 0);
    send_frame(0, 0, 8, 32'd65537, 0, 0, 0);
    send_frame(0, 0, 8, 32'd65536, 0, 0, 1);
    set_config(255, 8, 24'hFF_FFFF, 0);
    send_frame(0, 0, 8, 32'h0100_0000, 0, 0, 0);
    set_config(255, 8, 65536, 65535);
    send_frame(0, 0, 7, 0, 0, 0, 0);
    send_frame(0, 0, 8, 0, 0, 0, 0);
  endtask

  // Bytes after a complete frame, with and without an empty signature.
  task automatic test_trailing_bytes();
    set_config(255, 8, 65536, 51);
    send_frame(0, 0, 8, 0, 0, 5, 0);
    send_frame(2, 1, 8, 4, 3, 2, 0);
  endtask

  // Register extremes: zero and full-scale limits.
  task automatic test_register_extremes();
    set_config(0, 0, 0, 0);
    send_frame(0, 0, 0, 0, 1, 0, 0);
    send_frame(1, 0, 0, 0, 0, 0, 0);
    send_frame(0, 0, 16'hFFFF, 0, 0, 0, 0);
    send_frame(0, 0, 0, 1, 0, 0, 0);
    set_config(65535, 65535, 24'hFF_FFFF, 65535);
    send_frame(65535, 0, 8, 0, 0, 0, 0);
    send_frame(0, 0, 8, 0, 0, 0, 0);
  endtask

  // Mostly well-formed frames with random content and lengths near the limits,
  // with cut frames, trailing bytes and raw noise mixed in, over several settings.
  task automatic test_random_traffic(input int unsigned n_bytes);
    int unsigned stop_at;
    int unsigned phase_end;
    int unsigned r;
    int unsigned cap;
    logic [23:0] c_id, c_nonce, c_pay, c_min;
    logic [15:0] src, dst, nonce;
    logic [31:0] pay;
    stop_at = bytes_sent + n_bytes;
    for (int round = 0; bytes_sent < stop_at; round++) begin
      case ($urandom_range(0, 3))
        0:       c_id = 0;
        1:       c_id = $urandom_range(1, 16);
        2:       c_id = 65535;
        default: c_id = 255;
      endcase
      case ($urandom_range(0, 3))
        0:       c_nonce = 0;
        1:       c_nonce = $urandom_range(1, 16);
        2:       c_nonce = 65535;
        default: c_nonce = 8;
      endcase
      case ($urandom_range(0, 4))
        0:       c_pay = 0;
        1:       c_pay = $urandom_range(1, 64);
        2:       c_pay = 24'hFF_FFFF;
        3:       c_pay = 24'($urandom);
        default: c_pay = 65536;
      endcase
      case ($urandom_range(0, 5))
        0:       c_min = 0;
        1, 2:    c_min = 51;
        3:       c_min = $urandom_range(0, 120);
        4:       c_min = 65535;
        default: c_min = 40;
      endcase
      set_config(c_id, c_nonce, c_pay, c_min);
      no_idle   = (round % 3 == 1);
      phase_end = bytes_sent + 100;
      while (bytes_sent < phase_end && bytes_sent < stop_at) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          // raw noise with scattered final flags, always ending on one
          cap = $urandom_range(1, 20);
          for (int i = 0; i < cap; i++)
            send_byte(8'($urandom), (i == cap - 1) || ($urandom_range(0, 9) == 0));
        end else begin
          cap = (regs.max_id_length < 10) ? regs.max_id_length : 10;
          src = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, cap)) : 16'($urandom);
          dst = ($urandom_range(0, 99) < 85) ? 16'($urandom_range(0, cap)) : 16'($urandom);
          if ($urandom_range(0, 99) < 85)
            nonce = (regs.nonce_length <= 16) ? regs.nonce_length
                                               : 16'($urandom_range(0, 16));
          else
            nonce = 16'($urandom);
          r = $urandom_range(0, 99);
          cap = (regs.max_payload_length < 24) ? regs.max_payload_length : 24;
          if (r < 80)      pay = $urandom_range(0, cap);
          else if (r < 90) pay = {8'd0, regs.max_payload_length} + 32'd1;
          else             pay = $urandom;
          send_frame(src, dst, nonce, pay, 16'($urandom_range(0, 8)),
                     ($urandom_range(0, 99) < 20) ? $urandom_range(1, 5) : 0,
                     $urandom_range(0, 99) < 15);
        end
        // now and then hold off the sender until the block has drained
        if ($urandom_range(0, 29) == 0) wait_idle();
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.rx_byte  = '0;
    in_if.is_final = 1'b0;
    out_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.reg_index = '0;
    cfg_if.reg_data  = '0;
    mismatches  = 0;
    bytes_sent  = 0;
    stall_left  = 0;
    no_idle     = 1'b0;
    regs.max_id_length      = RST_MAX_ID;
    regs.nonce_length       = RST_NONCE_LEN;
    regs.max_payload_length = RST_MAX_PAY;
    regs.min_frame_length   = RST_MIN_FRAME;
    cur_phase   = PH_VERSION;
    field_pos   = '0;
    len_prefix  = '0;
    frame_bytes = '0;
    first_err   = ST_OK;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_default_frames();
    test_short_frames();
    test_length_errors();
    test_trailing_bytes();
    test_register_extremes();
    test_random_traffic(500);

    wait_idle();
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
